[sv/cmr_pkg.sv]
// ----------------------------------------------------------------------------
// cmr_pkg: shared types and constants for the cartridge mapper block
// Item modes, decoded bus addresses and the text-code conversion table.
// ----------------------------------------------------------------------------
`default_nettype none

package cmr_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_WRITE = 2'd0;
    localparam mode_t MODE_READ  = 2'd1;
    localparam mode_t MODE_TICK  = 2'd2;

    localparam logic [15:0] ADDR_LATCH_LO = 16'hD600;
    localparam logic [15:0] ADDR_LATCH_HI = 16'hD700;
    localparam logic [15:0] ADDR_IRQ_ACK  = 16'hD800;
    localparam logic [15:0] ADDR_IRQ_CTRL = 16'hD900;
    localparam logic [15:0] ADDR_NTRAM    = 16'hDA00;
    localparam logic [15:0] ADDR_CONV_LO  = 16'hDC00;
    localparam logic [15:0] ADDR_CONV_HI  = 16'hDD00;

    localparam int unsigned NUM_REGS = 16;

    // register file slots with a fixed meaning
    localparam logic [3:0] REG_PRG_6000 = 4'h0;
    localparam logic [3:0] REG_PRG_7000 = 4'h1;
    localparam logic [3:0] REG_PRG_8000 = 4'h2;
    localparam logic [3:0] REG_PRG_A000 = 4'h3;
    localparam logic [3:0] REG_PRG_C000 = 4'h4;
    localparam logic [3:0] REG_CHR      = 4'h5;
    localparam logic [3:0] REG_MIRROR   = 4'hA;
    localparam logic [3:0] REG_CONV_B   = 4'hB;
    localparam logic [3:0] REG_CONV_C   = 4'hC;
    localparam logic [3:0] REG_CONV_D   = 4'hD;

    localparam logic [6:0] PRG_E000_SINGLE = 7'd79;
    localparam logic [6:0] PRG_E000_DUAL   = 7'd127;

    // conversion table: row from reg C bits 6:5, column from reg D bits 6:4
    function automatic logic [7:0] conv_lookup(input logic [1:0] row, input logic [2:0] col);
        logic [7:0] t;
        t = 8'h00;
        unique case (row)
            2'd0: t = 8'h00;
            2'd1:
            begin
                unique case (col)
                    3'd2:    t = 8'h40;
                    3'd3:    t = 8'h10;
                    3'd4:    t = 8'h28;
                    3'd6:    t = 8'h18;
                    3'd7:    t = 8'h30;
                    default: t = 8'h00;
                endcase
            end
            2'd2:
            begin
                unique case (col)
                    3'd2:    t = 8'h48;
                    3'd3:    t = 8'h18;
                    3'd4:    t = 8'h30;
                    3'd5:    t = 8'h08;
                    3'd6:    t = 8'h20;
                    3'd7:    t = 8'h38;
                    default: t = 8'h00;
                endcase
            end
            2'd3:
            begin
                unique case (col)
                    3'd2:    t = 8'h80;
                    3'd3:    t = 8'h20;
                    3'd4:    t = 8'h38;
                    3'd5:    t = 8'h10;
                    3'd6:    t = 8'h28;
                    3'd7:    t = 8'hB0;
                    default: t = 8'h00;
                endcase
            end
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    // 8K bank number from a bank register
    function automatic logic [6:0] big_bank(input logic [7:0] r, input logic dual);
        logic [6:0] b;
        if (dual)
        begin
            b = {r[6], r[5:0]};
        end
        else
        begin
            b = {1'b0, r[5:0]} + {2'b00, r[6], 4'b0000};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[sv/cartridge_mapper_regs_irq_top.sv]
// ----------------------------------------------------------------------------
// cartridge_mapper_regs_irq_top: cartridge mapper registers and cycle IRQ
// Bus writes, conversion-port reads and cycle ticks; one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries mode, address, data, cycles.
//   Output channel (out_valid/out_stall) returns read_data, the IRQ level and
//   the current bank mapping, reflecting state after the item.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes dual_chip; it is
//   always ready. The user must write it only while the block is idle; the
//   block itself does not enforce this. Path: an item passes the input
//   register, then the result register. Throughput: one item per cycle
//   while out_stall is low; the state update and bank decode are a single
//   pass of logic between the two registers.
//   Stall: when out_stall is high with a result held, the input register
//   still fills once, then in_stall rises until the result is taken.
//   Reset: the register file, the IRQ latch/counter/enables and line, the
//   nametable shadow and dual_chip clear; no results are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_mapper_regs_irq_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data,
    // input items
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire cmr_pkg::mode_t       mode,
    input  wire logic [15:0]          address,
    input  wire logic [7:0]           data,
    input  wire logic [7:0]           cycles,
    // results
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [7:0]           read_data,
    output logic                      irq,
    output logic      [5:0]           prg_6000,
    output logic      [5:0]           prg_7000,
    output logic      [6:0]           prg_8000,
    output logic      [6:0]           prg_a000,
    output logic      [6:0]           prg_c000,
    output logic      [6:0]           prg_e000,
    output logic                      chr_low_bank,
    output logic                      mirror_mode,
    output logic      [1:0]           ntram_select
);
    import cmr_pkg::*;

    // input register
    logic        s1_valid_reg;
    mode_t       s1_mode_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_data_reg;
    logic [7:0]  s1_cycles_reg;

    // mapper state
    logic [7:0]  reg_file_reg [NUM_REGS];
    logic [7:0]  reg_file_next [NUM_REGS];
    logic [15:0] irq_latch_reg, irq_latch_next;
    logic [16:0] irq_counter_reg, irq_counter_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        ack_enable_reg, ack_enable_next;
    logic        irq_line_reg, irq_line_next;
    logic [1:0]  ntram_shadow_reg, ntram_shadow_next;
    logic        dual_chip_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic        irq_reg;
    logic [5:0]  prg_6000_reg, prg_7000_reg;
    logic [6:0]  prg_8000_reg, prg_a000_reg, prg_c000_reg, prg_e000_reg;
    logic        chr_low_bank_reg;
    logic        mirror_mode_reg;
    logic [1:0]  ntram_select_reg;

    logic        advance;
    logic        step;
    logic        in_xfer;
    logic [7:0]  conv_data;
    logic [7:0]  read_data_next;
    logic [16:0] tick_sum;

    assign advance   = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    cmr_conv u_conv (
        .reg_b     (reg_file_reg[REG_CONV_B]),
        .reg_c     (reg_file_reg[REG_CONV_C]),
        .reg_d     (reg_file_reg[REG_CONV_D]),
        .address   (s1_address_reg),
        .read_data (conv_data)
    );

    assign tick_sum = irq_counter_reg + {9'd0, s1_cycles_reg};

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            reg_file_next[i] = reg_file_reg[i];
        end
        irq_latch_next    = irq_latch_reg;
        irq_counter_next  = irq_counter_reg;
        irq_enable_next   = irq_enable_reg;
        ack_enable_next   = ack_enable_reg;
        irq_line_next     = irq_line_reg;
        ntram_shadow_next = ntram_shadow_reg;
        read_data_next    = 8'h00;

        unique case (s1_mode_reg)
            MODE_WRITE:
            begin
                if (s1_address_reg[15])
                begin
                    reg_file_next[s1_address_reg[11:8]] = s1_data_reg;
                    unique case (s1_address_reg)
                        ADDR_LATCH_LO: irq_latch_next = {irq_latch_reg[15:8], s1_data_reg};
                        ADDR_LATCH_HI: irq_latch_next = {s1_data_reg, irq_latch_reg[7:0]};
                        ADDR_IRQ_CTRL:
                        begin
                            irq_counter_next = {1'b0, irq_latch_reg};
                            irq_enable_next  = s1_data_reg[1];
                            ack_enable_next  = s1_data_reg[0];
                            irq_line_next    = 1'b0;
                        end
                        ADDR_IRQ_ACK:
                        begin
                            irq_enable_next = ack_enable_reg;
                            irq_line_next   = 1'b0;
                        end
                        // this write lands in register A, so its low bits are the data
                        ADDR_NTRAM: ntram_shadow_next = s1_data_reg[1:0];
                        default: ;
                    endcase
                end
            end
            MODE_READ: read_data_next = conv_data;
            MODE_TICK:
            begin
                if (irq_enable_reg)
                begin
                    if (tick_sum[16])
                    begin
                        irq_line_next    = 1'b1;
                        irq_counter_next = {1'b0, irq_latch_reg};
                    end
                    else
                    begin
                        irq_counter_next = tick_sum;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg    <= mode;
            s1_address_reg <= address;
            s1_data_reg    <= data;
            s1_cycles_reg  <= cycles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                reg_file_reg[i] <= 8'h00;
            end
            irq_latch_reg    <= 16'h0000;
            irq_counter_reg  <= 17'h00000;
            irq_enable_reg   <= 1'b0;
            ack_enable_reg   <= 1'b0;
            irq_line_reg     <= 1'b0;
            ntram_shadow_reg <= 2'b00;
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                reg_file_reg[i] <= reg_file_next[i];
            end
            irq_latch_reg    <= irq_latch_next;
            irq_counter_reg  <= irq_counter_next;
            irq_enable_reg   <= irq_enable_next;
            ack_enable_reg   <= ack_enable_next;
            irq_line_reg     <= irq_line_next;
            ntram_shadow_reg <= ntram_shadow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_chip_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dual_chip_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result fields reflect the state after this item
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            read_data_reg    <= read_data_next;
            irq_reg          <= irq_line_next;
            prg_6000_reg     <= reg_file_next[REG_PRG_6000][7:2]
                              | {5'b00000, reg_file_next[REG_PRG_6000][0]};
            prg_7000_reg     <= reg_file_next[REG_PRG_7000][7:2]
                              | {5'b00000, reg_file_next[REG_PRG_7000][0]};
            prg_8000_reg     <= big_bank(reg_file_next[REG_PRG_8000], dual_chip_reg);
            prg_a000_reg     <= big_bank(reg_file_next[REG_PRG_A000], dual_chip_reg);
            prg_c000_reg     <= big_bank(reg_file_next[REG_PRG_C000], dual_chip_reg);
            prg_e000_reg     <= dual_chip_reg ? PRG_E000_DUAL : PRG_E000_SINGLE;
            chr_low_bank_reg <= reg_file_next[REG_CHR][0];
            mirror_mode_reg  <= ~reg_file_next[REG_MIRROR][1];
            ntram_select_reg <= ntram_shadow_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign irq          = irq_reg;
    assign prg_6000     = prg_6000_reg;
    assign prg_7000     = prg_7000_reg;
    assign prg_8000     = prg_8000_reg;
    assign prg_a000     = prg_a000_reg;
    assign prg_c000     = prg_c000_reg;
    assign prg_e000     = prg_e000_reg;
    assign chr_low_bank = chr_low_bank_reg;
    assign mirror_mode  = mirror_mode_reg;
    assign ntram_select = ntram_select_reg;

endmodule

`default_nettype wire

[sv/cmr_conv.sv]
// ----------------------------------------------------------------------------
// cmr_conv: text-code conversion read port
// Builds the high/low conversion bytes from registers B, C, D and the table.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_conv (
    input  wire logic [7:0]  reg_b,
    input  wire logic [7:0]  reg_c,
    input  wire logic [7:0]  reg_d,
    input  wire logic [15:0] address,
    output logic      [7:0]  read_data
);
    import cmr_pkg::*;

    logic [7:0] t;
    logic [7:0] hi;
    logic [7:0] lo;

    always_comb
    begin
        t  = conv_lookup(reg_c[6:5], reg_d[6:4]);
        hi = 8'h40 | {2'b00, t[5:0]} | {5'b00000, reg_d[3:1]} | {reg_b[2], 7'b0000000};
        // table bit 6 forces bit 2 low, bit 7 forces it high
        if (t[6])
        begin
            hi[2] = 1'b0;
        end
        else if (t[7])
        begin
            hi[2] = 1'b1;
        end
        lo = {reg_d[0], reg_c[4:0], reg_b[1:0]};

        priority if (address == ADDR_CONV_HI)
        begin
            read_data = hi;
        end
        else if (address == ADDR_CONV_LO)
        begin
            read_data = lo;
        end
        else
        begin
            read_data = 8'h00;
        end
    end

endmodule

`default_nettype wire
